[rtl/midi_track_event_parser_defines.svh]
// Assertion macros shared by the track parser RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef MIDI_TRACK_EVENT_PARSER_DEFINES_SVH
`define MIDI_TRACK_EVENT_PARSER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MTEP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define MTEP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/mtep_pkg.sv]
// Types and constants for the MIDI track event parser.
// No dependencies; used by every other file of the block but the assertion macro header.
package mtep_pkg;

  localparam int MAX_TRACKS = 256;
  localparam int TRACK_W    = 8;
  localparam int TICK_W     = 52;
  localparam int VLQ_W      = 28;
  localparam int VLQ_CNT_W  = 3;
  localparam int NOTE_W     = 25;
  localparam int TEMPO_W    = 24;
  localparam int MASK_W     = 16;

  localparam logic [VLQ_CNT_W-1:0] VLQ_MAX_BYTES = 3'd4;

  localparam logic [7:0] STATUS_META      = 8'hFF;
  localparam logic [7:0] STATUS_SYSEX     = 8'hF0;
  localparam logic [7:0] STATUS_SYSEX_ESC = 8'hF7;
  localparam logic [7:0] STATUS_SYSTEM    = 8'hF0;
  localparam logic [7:0] META_TEMPO       = 8'h51;
  localparam logic [7:0] META_PORT        = 8'h21;
  localparam logic [7:0] META_END         = 8'h2F;
  localparam logic [7:0] PROGRAM_NONE     = 8'hFF;

  localparam logic [3:0] CH_NOTE_ON  = 4'h9;
  localparam logic [3:0] CH_PROGRAM  = 4'hC;
  localparam logic [3:0] CH_PRESSURE = 4'hD;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_TRACK_NUMBER = 1'b0;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef enum logic [1:0] {
    KIND_CHANNEL = 2'd0,
    KIND_TEMPO   = 2'd1,
    KIND_END     = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_TRUNCATED = 4'd1,
    ERR_ORPHAN    = 4'd2,
    ERR_LONG_VLQ  = 4'd3,
    ERR_BAD_TEMPO = 4'd4,
    ERR_PORT      = 4'd5,
    ERR_BAD_END   = 4'd6,
    ERR_SYSTEM    = 4'd7,
    ERR_DATA_HIGH = 4'd8,
    ERR_NO_END    = 4'd9
  } error_t;

  typedef enum logic [9:0] {
    ST_DELTA     = 10'b00_0000_0001,
    ST_STATUS    = 10'b00_0000_0010,
    ST_DATA1     = 10'b00_0000_0100,
    ST_DATA2     = 10'b00_0000_1000,
    ST_DATA2_BAD = 10'b00_0001_0000,
    ST_META_TYPE = 10'b00_0010_0000,
    ST_LENGTH    = 10'b00_0100_0000,
    ST_PAYLOAD   = 10'b00_1000_0000,
    ST_DONE      = 10'b01_0000_0000,
    ST_HALT      = 10'b10_0000_0000
  } stage_t;

  typedef struct packed {
    kind_t                result_kind;
    logic [TICK_W-1:0]    event_tick;
    logic [TRACK_W-1:0]   track_index;
    logic [7:0]           status_byte;
    logic [6:0]           data_first;
    logic [6:0]           data_second;
    logic [TEMPO_W-1:0]   tempo_value;
    error_t               error_code;
    logic [MASK_W-1:0]    channels_used;
    logic [NOTE_W-1:0]    note_on_count;
    logic signed [7:0]    first_program;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  typedef struct packed {
    logic not_empty;
    logic room_for_two;
  } queue_status_t;

endpackage

[rtl/mtep_if.sv]
// Handshake channels of the track parser: raw bytes in, results out.
// Depends on mtep_pkg for field widths.
interface mtep_data_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface mtep_result_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      result_kind;
  logic [mtep_pkg::TICK_W-1:0]     event_tick;
  logic [mtep_pkg::TRACK_W-1:0]    track_index;
  logic [7:0]                      status_byte;
  logic [6:0]                      data_first;
  logic [6:0]                      data_second;
  logic [mtep_pkg::TEMPO_W-1:0]    tempo_value;
  logic [3:0]                      error_code;
  logic [mtep_pkg::MASK_W-1:0]     channels_used;
  logic [mtep_pkg::NOTE_W-1:0]     note_on_count;
  logic signed [7:0]               first_program;
  logic                            last;

  modport source (output valid, result_kind, event_tick, track_index, status_byte,
                  data_first, data_second, tempo_value, error_code, channels_used,
                  note_on_count, first_program, last, input ready);
  modport sink   (input valid, result_kind, event_tick, track_index, status_byte,
                  data_first, data_second, tempo_value, error_code, channels_used,
                  note_on_count, first_program, last, output ready);
endinterface

[rtl/mtep_result_queue.sv]
// Four-entry result queue: up to two writes and one read per cycle.
// Depends on mtep_pkg for result_t, push_t and queue sizing.
module mtep_result_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  mtep_pkg::push_t         push,
  input  mtep_pkg::result_t       wdata0,
  input  mtep_pkg::result_t       wdata1,
  input  logic                    pop,
  output mtep_pkg::result_t       head,
  output mtep_pkg::queue_status_t status
);

  mtep_pkg::result_t                entries [mtep_pkg::QUEUE_DEPTH];
  logic [mtep_pkg::QPTR_W-1:0]      wr_ptr;
  logic [mtep_pkg::QPTR_W-1:0]      rd_ptr;
  logic [mtep_pkg::QCNT_W-1:0]      count;
  logic [mtep_pkg::QPTR_W-1:0]      wr_ptr_next;
  logic [mtep_pkg::QPTR_W-1:0]      wr_ptr_plus1;
  logic [mtep_pkg::QCNT_W-1:0]      count_next;
  logic [mtep_pkg::QCNT_W-1:0]      push_n;

  assign wr_ptr_plus1 = mtep_pkg::QPTR_W'(wr_ptr + 1'b1);
  assign push_n = mtep_pkg::QCNT_W'(push.first) + mtep_pkg::QCNT_W'(push.second);

  always_comb begin
    wr_ptr_next = mtep_pkg::QPTR_W'(wr_ptr + push_n[mtep_pkg::QPTR_W-1:0]);
    count_next  = mtep_pkg::QCNT_W'(count + push_n - mtep_pkg::QCNT_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      entries[wr_ptr] <= wdata0;
    end
    if (push.second) begin
      entries[wr_ptr_plus1] <= wdata1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= mtep_pkg::QPTR_W'(rd_ptr + 1'b1);
      end
    end
  end

  assign head                = entries[rd_ptr];
  assign status.not_empty    = (count != '0);
  assign status.room_for_two = (count <= mtep_pkg::QCNT_W'(mtep_pkg::QUEUE_DEPTH - 2));

endmodule

[rtl/midi_track_event_parser.sv]
// Top level of the MIDI track event parser: byte decoder, track state, APB register.
// Depends on mtep_pkg, mtep_if, mtep_result_queue and the assertion macro header.
//
// Takes one MTrk chunk body byte per cycle and emits channel, tempo, end-of-track
// and error results with per-track statistics. Each accepted byte is decoded combinationally
// and yields zero, one or two results, which go into a four-entry result queue;
// a byte is accepted whenever two queue entries are free, so the sustained rate is one
// byte per cycle as long as results are taken about as fast as they are produced.
// A byte with first_byte set clears all track state before it is decoded. After an
// error or end-of-track, bytes are ignored until the next first_byte. Register 0
// (byte address 0) holds track_number and should only be written while idle.
`include "midi_track_event_parser_defines.svh"

module midi_track_event_parser (
  input  logic                             clk,
  input  logic                             rst,
  mtep_data_if.sink                        data_ch,
  mtep_result_if.source                    result_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mtep_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [mtep_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [mtep_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  // track state
  mtep_pkg::stage_t                   stage, stage_next;
  logic [mtep_pkg::TICK_W-1:0]        tick, tick_next;
  logic [7:0]                         running_status, running_status_next;
  logic [mtep_pkg::VLQ_W-1:0]         vlq_acc, vlq_acc_next;
  logic [mtep_pkg::VLQ_CNT_W-1:0]     vlq_cnt, vlq_cnt_next;
  logic [7:0]                         cur_status, cur_status_next;
  logic [7:0]                         meta_type, meta_type_next;
  logic [mtep_pkg::VLQ_W-1:0]         payload_rem, payload_rem_next;
  logic [mtep_pkg::TEMPO_W-1:0]       payload_shift, payload_shift_next;
  logic [6:0]                         held_data, held_data_next;
  logic [mtep_pkg::MASK_W-1:0]        chan_mask, chan_mask_next;
  logic [mtep_pkg::NOTE_W-1:0]        note_count, note_count_next;
  logic [7:0]                         program_seen, program_seen_next;
  mtep_pkg::error_t                   pending_error, pending_error_next;
  logic [mtep_pkg::TRACK_W-1:0]       track_number;

  // present values after an optional first_byte clear
  mtep_pkg::stage_t                   c_stage;
  logic [mtep_pkg::TICK_W-1:0]        c_tick;
  logic [7:0]                         c_running_status;
  logic [mtep_pkg::VLQ_W-1:0]         c_vlq_acc;
  logic [mtep_pkg::VLQ_CNT_W-1:0]     c_vlq_cnt;
  logic [7:0]                         c_cur_status;
  logic [7:0]                         c_meta_type;
  logic [mtep_pkg::VLQ_W-1:0]         c_payload_rem;
  logic [mtep_pkg::TEMPO_W-1:0]       c_payload_shift;
  logic [6:0]                         c_held_data;
  logic [mtep_pkg::MASK_W-1:0]        c_chan_mask;
  logic [mtep_pkg::NOTE_W-1:0]        c_note_count;
  logic [7:0]                         c_program_seen;
  mtep_pkg::error_t                   c_pending_error;

  logic [7:0]                         d;
  logic                               accept;
  logic [mtep_pkg::VLQ_W-1:0]         vlq_shift;
  logic [mtep_pkg::VLQ_W-1:0]         delta_vlq;
  logic [mtep_pkg::VLQ_CNT_W-1:0]     vlq_cnt_inc;
  logic [mtep_pkg::VLQ_W-1:0]         rem_dec;
  logic [mtep_pkg::TEMPO_W-1:0]       shift_in;

  logic                               ch_go;
  logic [7:0]                         ch_status;
  logic [6:0]                         ch_a;
  logic [6:0]                         ch_b;
  logic                               fd_go;
  logic [7:0]                         fd_status;
  logic                               fin_go;
  logic [mtep_pkg::TEMPO_W-1:0]       fin_shift;
  mtep_pkg::error_t                   fin_pend;
  logic                               fail_go;
  mtep_pkg::error_t                   fail_code;
  logic                               tempo_go;
  logic                               end_go;
  logic                               a_valid;
  logic                               lb_err;
  mtep_pkg::error_t                   lb_code;
  logic [mtep_pkg::TRACK_W-1:0]       track_idx;

  mtep_pkg::result_t                  res_base, res_a, res_b;
  mtep_pkg::result_t                  wdata0, wdata1, head;
  mtep_pkg::push_t                    push;
  mtep_pkg::queue_status_t            q_stat;
  logic                               pop;
  logic                               cfg_write;

  assign d      = data_ch.data_byte;
  assign accept = data_ch.valid && data_ch.ready;

  assign track_idx = ({1'b0, track_number} >= 9'(mtep_pkg::MAX_TRACKS)) ?
                     mtep_pkg::TRACK_W'(mtep_pkg::MAX_TRACKS - 1) : track_number;

  always_comb begin
    if (data_ch.first_byte) begin
      c_stage          = mtep_pkg::ST_DELTA;
      c_tick           = '0;
      c_running_status = '0;
      c_vlq_acc        = '0;
      c_vlq_cnt        = '0;
      c_cur_status     = '0;
      c_meta_type      = '0;
      c_payload_rem    = '0;
      c_payload_shift  = '0;
      c_held_data      = '0;
      c_chan_mask      = '0;
      c_note_count     = '0;
      c_program_seen   = mtep_pkg::PROGRAM_NONE;
      c_pending_error  = mtep_pkg::ERR_NONE;
    end else begin
      c_stage          = stage;
      c_tick           = tick;
      c_running_status = running_status;
      c_vlq_acc        = vlq_acc;
      c_vlq_cnt        = vlq_cnt;
      c_cur_status     = cur_status;
      c_meta_type      = meta_type;
      c_payload_rem    = payload_rem;
      c_payload_shift  = payload_shift;
      c_held_data      = held_data;
      c_chan_mask      = chan_mask;
      c_note_count     = note_count;
      c_program_seen   = program_seen;
      c_pending_error  = pending_error;
    end
  end

  assign vlq_shift   = {c_vlq_acc[mtep_pkg::VLQ_W-8:0], d[6:0]};
  assign delta_vlq   = {((c_vlq_cnt == '0) ? '0 : c_vlq_acc[mtep_pkg::VLQ_W-8:0]), d[6:0]};
  assign vlq_cnt_inc = mtep_pkg::VLQ_CNT_W'(c_vlq_cnt + 1'b1);
  assign rem_dec     = (c_payload_rem != '0) ? mtep_pkg::VLQ_W'(c_payload_rem - 1'b1) : '0;
  assign shift_in    = {c_payload_shift[mtep_pkg::TEMPO_W-9:0], d};

  always_comb begin
    stage_next          = c_stage;
    tick_next           = c_tick;
    running_status_next = c_running_status;
    vlq_acc_next        = c_vlq_acc;
    vlq_cnt_next        = c_vlq_cnt;
    cur_status_next     = c_cur_status;
    meta_type_next      = c_meta_type;
    payload_rem_next    = c_payload_rem;
    payload_shift_next  = c_payload_shift;
    held_data_next      = c_held_data;
    chan_mask_next      = c_chan_mask;
    note_count_next     = c_note_count;
    program_seen_next   = c_program_seen;
    pending_error_next  = c_pending_error;

    ch_go     = 1'b0;
    ch_status = c_cur_status;
    ch_a      = '0;
    ch_b      = '0;
    fd_go     = 1'b0;
    fd_status = c_cur_status;
    fin_go    = 1'b0;
    fin_shift = c_payload_shift;
    fin_pend  = c_pending_error;
    fail_go   = 1'b0;
    fail_code = mtep_pkg::ERR_NONE;
    tempo_go  = 1'b0;
    end_go    = 1'b0;

    case (c_stage)
      mtep_pkg::ST_DELTA: begin
        if (!d[7]) begin
          vlq_cnt_next = '0;
          vlq_acc_next = '0;
          tick_next    = mtep_pkg::TICK_W'(c_tick + mtep_pkg::TICK_W'(delta_vlq));
          stage_next   = mtep_pkg::ST_STATUS;
        end else if (vlq_cnt_inc >= mtep_pkg::VLQ_MAX_BYTES) begin
          vlq_cnt_next = '0;
          vlq_acc_next = delta_vlq;
          fail_go      = 1'b1;
          fail_code    = mtep_pkg::ERR_LONG_VLQ;
        end else begin
          vlq_cnt_next = vlq_cnt_inc;
          vlq_acc_next = delta_vlq;
        end
      end
      mtep_pkg::ST_STATUS: begin
        if (!d[7]) begin
          if (c_running_status == '0) begin
            fail_go   = 1'b1;
            fail_code = mtep_pkg::ERR_ORPHAN;
          end else begin
            cur_status_next = c_running_status;
            fd_go           = 1'b1;
            fd_status       = c_running_status;
          end
        end else if (d == mtep_pkg::STATUS_META || d == mtep_pkg::STATUS_SYSEX ||
                     d == mtep_pkg::STATUS_SYSEX_ESC) begin
          running_status_next = '0;
          cur_status_next     = d;
          meta_type_next      = '0;
          vlq_acc_next        = '0;
          vlq_cnt_next        = '0;
          stage_next = (d == mtep_pkg::STATUS_META) ? mtep_pkg::ST_META_TYPE
                                                    : mtep_pkg::ST_LENGTH;
        end else if (d >= mtep_pkg::STATUS_SYSTEM) begin
          fail_go   = 1'b1;
          fail_code = mtep_pkg::ERR_SYSTEM;
        end else begin
          running_status_next = d;
          cur_status_next     = d;
          stage_next          = mtep_pkg::ST_DATA1;
        end
      end
      mtep_pkg::ST_DATA1: begin
        fd_go = 1'b1;
      end
      mtep_pkg::ST_DATA2, mtep_pkg::ST_DATA2_BAD: begin
        if (c_stage == mtep_pkg::ST_DATA2_BAD || d[7]) begin
          fail_go   = 1'b1;
          fail_code = mtep_pkg::ERR_DATA_HIGH;
        end else begin
          ch_go = 1'b1;
          ch_a  = c_held_data;
          ch_b  = d[6:0];
        end
      end
      mtep_pkg::ST_META_TYPE: begin
        meta_type_next = d;
        vlq_acc_next   = '0;
        vlq_cnt_next   = '0;
        stage_next     = mtep_pkg::ST_LENGTH;
      end
      mtep_pkg::ST_LENGTH: begin
        if (!d[7]) begin
          vlq_cnt_next       = '0;
          vlq_acc_next       = '0;
          payload_shift_next = '0;
          payload_rem_next   = vlq_shift;
          pending_error_next = mtep_pkg::ERR_NONE;
          if (c_cur_status == mtep_pkg::STATUS_META) begin
            if (c_meta_type == mtep_pkg::META_TEMPO && vlq_shift != 28'd3) begin
              pending_error_next = mtep_pkg::ERR_BAD_TEMPO;
            end else if (c_meta_type == mtep_pkg::META_PORT && vlq_shift != 28'd1) begin
              pending_error_next = mtep_pkg::ERR_PORT;
            end else if (c_meta_type == mtep_pkg::META_END && vlq_shift != '0) begin
              pending_error_next = mtep_pkg::ERR_BAD_END;
            end
          end
          if (vlq_shift == '0) begin
            fin_go    = 1'b1;
            fin_shift = '0;
            fin_pend  = pending_error_next;
          end else begin
            stage_next = mtep_pkg::ST_PAYLOAD;
          end
        end else if (vlq_cnt_inc >= mtep_pkg::VLQ_MAX_BYTES) begin
          vlq_cnt_next = '0;
          vlq_acc_next = vlq_shift;
          fail_go      = 1'b1;
          fail_code    = mtep_pkg::ERR_LONG_VLQ;
        end else begin
          vlq_cnt_next = vlq_cnt_inc;
          vlq_acc_next = vlq_shift;
        end
      end
      mtep_pkg::ST_PAYLOAD: begin
        payload_shift_next = shift_in;
        payload_rem_next   = rem_dec;
        if (rem_dec == '0) begin
          fin_go    = 1'b1;
          fin_shift = shift_in;
          fin_pend  = c_pending_error;
        end
      end
      default: begin
      end
    endcase

    // first data byte of a channel event
    if (fd_go) begin
      if (fd_status[7:4] == mtep_pkg::CH_PROGRAM || fd_status[7:4] == mtep_pkg::CH_PRESSURE) begin
        if (d[7]) begin
          fail_go   = 1'b1;
          fail_code = mtep_pkg::ERR_DATA_HIGH;
        end else begin
          ch_go = 1'b1;
          ch_a  = d[6:0];
          ch_b  = '0;
        end
      end else begin
        held_data_next = d[6:0];
        stage_next     = d[7] ? mtep_pkg::ST_DATA2_BAD : mtep_pkg::ST_DATA2;
      end
      ch_status = fd_status;
    end

    if (ch_go) begin
      chan_mask_next = c_chan_mask | (mtep_pkg::MASK_W'(1) << ch_status[3:0]);
      if (ch_status[7:4] == mtep_pkg::CH_NOTE_ON && ch_b != '0 && c_note_count != '1) begin
        note_count_next = mtep_pkg::NOTE_W'(c_note_count + 1'b1);
      end
      if (ch_status[7:4] == mtep_pkg::CH_PROGRAM && c_program_seen == mtep_pkg::PROGRAM_NONE) begin
        program_seen_next = {1'b0, ch_a};
      end
      stage_next = mtep_pkg::ST_DELTA;
    end

    if (fin_go) begin
      stage_next = mtep_pkg::ST_DELTA;
      if (c_cur_status == mtep_pkg::STATUS_META) begin
        if (fin_pend != mtep_pkg::ERR_NONE) begin
          fail_go   = 1'b1;
          fail_code = fin_pend;
        end else if (c_meta_type == mtep_pkg::META_TEMPO) begin
          if (fin_shift == '0) begin
            fail_go   = 1'b1;
            fail_code = mtep_pkg::ERR_BAD_TEMPO;
          end else begin
            tempo_go = 1'b1;
          end
        end else if (c_meta_type == mtep_pkg::META_PORT) begin
          if (fin_shift != '0) begin
            fail_go   = 1'b1;
            fail_code = mtep_pkg::ERR_PORT;
          end
        end else if (c_meta_type == mtep_pkg::META_END) begin
          end_go     = 1'b1;
          stage_next = mtep_pkg::ST_DONE;
        end
      end
    end

    if (fail_go) begin
      stage_next = mtep_pkg::ST_HALT;
    end

    a_valid = ch_go || tempo_go || end_go || fail_go;

    lb_err  = data_ch.last_byte && stage_next != mtep_pkg::ST_DONE &&
              stage_next != mtep_pkg::ST_HALT;
    lb_code = (stage_next == mtep_pkg::ST_DELTA && vlq_cnt_next == '0) ?
              mtep_pkg::ERR_NO_END : mtep_pkg::ERR_TRUNCATED;
    if (lb_err) begin
      stage_next = mtep_pkg::ST_HALT;
    end
  end

  // result assembly
  always_comb begin
    res_base.result_kind   = mtep_pkg::KIND_CHANNEL;
    res_base.event_tick    = tick_next;
    res_base.track_index   = track_idx;
    res_base.status_byte   = '0;
    res_base.data_first    = '0;
    res_base.data_second   = '0;
    res_base.tempo_value   = '0;
    res_base.error_code    = mtep_pkg::ERR_NONE;
    res_base.channels_used = chan_mask_next;
    res_base.note_on_count = note_count_next;
    res_base.first_program = program_seen_next;
    res_base.last          = 1'b1;

    res_a = res_base;
    if (fail_go) begin
      res_a.result_kind = mtep_pkg::KIND_ERROR;
      res_a.error_code  = fail_code;
    end else if (tempo_go) begin
      res_a.result_kind = mtep_pkg::KIND_TEMPO;
      res_a.tempo_value = fin_shift;
    end else if (end_go) begin
      res_a.result_kind = mtep_pkg::KIND_END;
    end else begin
      res_a.status_byte = ch_status;
      res_a.data_first  = ch_a;
      res_a.data_second = ch_b;
    end
    res_a.last = !lb_err;

    res_b             = res_base;
    res_b.result_kind = mtep_pkg::KIND_ERROR;
    res_b.error_code  = lb_code;

    if (a_valid) begin
      push.first  = accept;
      push.second = accept && lb_err;
      wdata0      = res_a;
      wdata1      = res_b;
    end else begin
      push.first  = accept && lb_err;
      push.second = 1'b0;
      wdata0      = res_b;
      wdata1      = res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage          <= mtep_pkg::ST_DELTA;
      tick           <= '0;
      running_status <= '0;
      vlq_acc        <= '0;
      vlq_cnt        <= '0;
      cur_status     <= '0;
      meta_type      <= '0;
      payload_rem    <= '0;
      payload_shift  <= '0;
      held_data      <= '0;
      chan_mask      <= '0;
      note_count     <= '0;
      program_seen   <= mtep_pkg::PROGRAM_NONE;
      pending_error  <= mtep_pkg::ERR_NONE;
    end else if (accept) begin
      stage          <= stage_next;
      tick           <= tick_next;
      running_status <= running_status_next;
      vlq_acc        <= vlq_acc_next;
      vlq_cnt        <= vlq_cnt_next;
      cur_status     <= cur_status_next;
      meta_type      <= meta_type_next;
      payload_rem    <= payload_rem_next;
      payload_shift  <= payload_shift_next;
      held_data      <= held_data_next;
      chan_mask      <= chan_mask_next;
      note_count     <= note_count_next;
      program_seen   <= program_seen_next;
      pending_error  <= pending_error_next;
    end
  end

  // configuration register
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[mtep_pkg::APB_ADDR_W-1:2] == mtep_pkg::REG_TRACK_NUMBER);

  always_ff @(posedge clk) begin
    if (rst) begin
      track_number <= '0;
    end else if (cfg_write) begin
      track_number <= pwdata[mtep_pkg::TRACK_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[mtep_pkg::APB_ADDR_W-1:2] == mtep_pkg::REG_TRACK_NUMBER) ?
                  mtep_pkg::APB_DATA_W'(track_number) : '0;

  mtep_result_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata0 (wdata0),
    .wdata1 (wdata1),
    .pop    (pop),
    .head   (head),
    .status (q_stat)
  );

  assign data_ch.ready = q_stat.room_for_two && !rst;
  assign pop           = result_ch.valid && result_ch.ready;

  assign result_ch.valid         = q_stat.not_empty;
  assign result_ch.result_kind   = head.result_kind;
  assign result_ch.event_tick    = head.event_tick;
  assign result_ch.track_index   = head.track_index;
  assign result_ch.status_byte   = head.status_byte;
  assign result_ch.data_first    = head.data_first;
  assign result_ch.data_second   = head.data_second;
  assign result_ch.tempo_value   = head.tempo_value;
  assign result_ch.error_code    = head.error_code;
  assign result_ch.channels_used = head.channels_used;
  assign result_ch.note_on_count = head.note_on_count;
  assign result_ch.first_program = head.first_program;
  assign result_ch.last          = head.last;

  `MTEP_ASSERT_NOW(a_halt_silent, (accept && stage == mtep_pkg::ST_HALT && !data_ch.first_byte), (!push.first), "halted parser produced a result")
  `MTEP_ASSERT_NOW(a_pair_last, (push.second), (push.first && !wdata0.last && wdata1.last), "result pair has wrong last marking")
  `MTEP_ASSERT_NEXT(a_tick_hold, (!accept), ($stable(tick)), "tick changed without an accepted item")
  `MTEP_ASSERT_NEXT(a_mask_grow, (accept && !data_ch.first_byte), ((chan_mask & $past(chan_mask)) == $past(chan_mask)), "channel mask lost a bit within a track")

endmodule
